[hdl/sparse_fiber_matrix_accumulate_macros.svh]
// Assertion macros shared by the sparse fiber accumulate RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef SPARSE_FIBER_MATRIX_ACCUMULATE_MACROS_SVH
`define SPARSE_FIBER_MATRIX_ACCUMULATE_MACROS_SVH

// check in the same cycle
`define SFMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// check in the next cycle
`define SFMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/sfma_pkg.sv]
// Package for the sparse fiber matrix accumulate block: types, constants, helpers.
// No dependencies.
package sfma_pkg;

  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_COLS_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int ACC_W        = 48;
  localparam int ACC_DEPTH    = 16;
  localparam int ACC_AW       = 4;
  localparam int CFG_W        = 5;
  localparam logic [CFG_W-1:0] CFG_COLS_RESET = 5'd16;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_NONZERO = 1'b1;

  typedef struct packed {
    logic                     command;
    logic [7:0]               row_index;
    logic [3:0]               col_index;
    logic signed [DATA_W-1:0] data_value;
    logic                     fiber_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]               out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                     out_last;
  } out_item_t;

  typedef struct packed {
    logic              rd_en;
    logic [ACC_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ACC_AW-1:0] wr_addr;
    logic [ACC_W-1:0]  wr_data;
    logic              clr;
  } acc_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_WR
  } seq_state_t;

  function automatic logic [DATA_W-1:0] sat48(input logic [ACC_W-1:0] a);
    logic [ACC_W-DATA_W:0] top;
    top = a[ACC_W-1:DATA_W-1];
    if (top == '0 || top == '1) begin
      return a[DATA_W-1:0];
    end else if (a[ACC_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

[hdl/sfma_weight_mem.sv]
// Dense matrix storage: single-port write, registered read.
// Depends on sfma_pkg.
module sfma_weight_mem
  import sfma_pkg::*;
#(
  parameter int DEPTH = MAX_ROWS_DEF * MAX_COLS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/sfma_acc_mem.sv]
// Accumulator row storage with per-entry valid bits; invalid entries read as zero.
// Depends on sfma_pkg.
module sfma_acc_mem
  import sfma_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  acc_req_t         req,
  output logic [ACC_W-1:0] rd_data
);

  logic [ACC_W-1:0]     mem [ACC_DEPTH];
  logic [ACC_DEPTH-1:0] vld_r;
  logic [ACC_W-1:0]     rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clr) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= vld_r[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/sfma_seq.sv]
// Sequencer: column count register, multiply-accumulate pipeline, emit and output register.
// Depends on sfma_pkg and the assertion macro header.
`include "sparse_fiber_matrix_accumulate_macros.svh"
module sfma_seq
  import sfma_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  localparam int WAW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output logic              w_wr_en,
  output logic [WAW-1:0]    w_wr_addr,
  output logic [DATA_W-1:0] w_wr_data,
  output logic              w_rd_en,
  output logic [WAW-1:0]    w_rd_addr,
  input  logic [DATA_W-1:0] w_rd_data,
  output acc_req_t          acc_req,
  input  logic [ACC_W-1:0]  acc_rd_data
);

  localparam int COL_LIMIT = (MAX_COLS < ACC_DEPTH) ? MAX_COLS : ACC_DEPTH;

  seq_state_t               state_r, state_nxt;
  logic [ACC_AW-1:0]        k_r, k_nxt;
  logic [CFG_W-1:0]         cols_r;
  logic [CFG_W-1:0]         n_eff;
  logic                     k_last;
  logic [7:0]               row_r;
  logic signed [DATA_W-1:0] x_r;
  logic                     end_r;
  logic                     s1_v_r, s2_v_r;
  logic [ACC_AW-1:0]        s1_col_r, s2_col_r;
  logic signed [63:0]       prod_r;
  logic [ACC_W-1:0]         acc_hold_r;
  out_item_t                out_r;
  logic                     out_valid_r;
  logic                     out_load;
  logic                     in_take;
  logic                     row_ok;
  logic                     load_ok;

  always_comb begin
    if (cols_r == '0) begin
      n_eff = CFG_W'(1);
    end else if (int'(cols_r) > COL_LIMIT) begin
      n_eff = CFG_W'(COL_LIMIT);
    end else begin
      n_eff = cols_r;
    end
  end

  assign k_last  = ({1'b0, k_r} == (n_eff - CFG_W'(1)));
  assign row_ok  = int'(in_data.row_index) < MAX_ROWS;
  assign load_ok = row_ok && (int'(in_data.col_index) < MAX_COLS);
  assign in_take = in_valid && in_ready;

  assign w_wr_en   = in_take && (in_data.command == CMD_LOAD) && load_ok;
  assign w_wr_addr = WAW'(int'(in_data.row_index) * MAX_COLS + int'(in_data.col_index));
  assign w_wr_data = in_data.data_value;
  assign w_rd_addr = WAW'(int'(row_r) * MAX_COLS + int'(k_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      cols_r  <= CFG_COLS_RESET;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (cfg_we) begin
        cols_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    state_nxt        = state_r;
    k_nxt            = k_r;
    in_ready         = 1'b0;
    w_rd_en          = 1'b0;
    out_load         = 1'b0;
    acc_req          = '0;
    acc_req.wr_en    = s2_v_r;
    acc_req.wr_addr  = s2_col_r;
    acc_req.wr_data  = acc_hold_r + prod_r[63:16];
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        k_nxt    = '0;
        if (in_valid && in_data.command == CMD_NONZERO) begin
          if (row_ok) begin
            state_nxt = ST_MAC;
          end else if (in_data.fiber_end) begin
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      ST_MAC: begin
        w_rd_en         = 1'b1;
        acc_req.rd_en   = 1'b1;
        acc_req.rd_addr = k_r;
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + ACC_AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!s1_v_r && !s2_v_r) begin
          state_nxt = end_r ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        acc_req.rd_en   = 1'b1;
        acc_req.rd_addr = k_r;
        state_nxt       = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (k_last) begin
            acc_req.clr = 1'b1;
            k_nxt       = '0;
            state_nxt   = ST_IDLE;
          end else begin
            k_nxt     = k_r + ACC_AW'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_take && in_data.command == CMD_NONZERO) begin
      row_r <= in_data.row_index;
      x_r   <= in_data.data_value;
      end_r <= in_data.fiber_end;
    end
    s1_col_r   <= k_r;
    s2_col_r   <= s1_col_r;
    prod_r     <= x_r * $signed(w_rd_data);
    acc_hold_r <= acc_rd_data;
    if (out_load) begin
      out_r.out_col   <= k_r;
      out_r.out_value <= sat48(acc_rd_data);
      out_r.out_last  <= k_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r <= (state_r == ST_MAC);
      s2_v_r <= s1_v_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SFMA_ASSERT_NOW(a_idle_drained, in_ready, !s1_v_r && !s2_v_r, "transaction accepted with MAC in flight")
  `SFMA_ASSERT_NOW(a_clr_no_wr, acc_req.clr, !acc_req.wr_en, "accumulator clear collides with write")
  `SFMA_ASSERT_NOW(a_emit_fresh, state_r == ST_EMIT_WR, $past(state_r) == ST_EMIT_RD || $past(state_r) == ST_EMIT_WR, "emit without accumulator read")
  `SFMA_ASSERT_NEXT(a_clr_idle, acc_req.clr, state_r == ST_IDLE && !s1_v_r && out_valid_r, "fiber end did not return to idle")

endmodule

[hdl/sparse_fiber_matrix_accumulate.sv]
// Sparse tensor times dense matrix, fiber kernel, Q16.16 data with 48-bit accumulators.
// Load transactions write the weight memory as they are taken. For a nonzero, the
// weight and accumulator memories are read one column per cycle through a
// read / multiply / write-back pipeline. A fiber end then reads each accumulator
// entry once into the output register. Results leave through an output register,
// and the next transaction is taken while the last result of a fiber still waits.
// Depends on sfma_pkg, sfma_seq, sfma_weight_mem and sfma_acc_mem.
module sparse_fiber_matrix_accumulate
  import sfma_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int WDEPTH = MAX_ROWS * MAX_COLS;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

  logic              w_wr_en;
  logic [WAW-1:0]    w_wr_addr;
  logic [DATA_W-1:0] w_wr_data;
  logic              w_rd_en;
  logic [WAW-1:0]    w_rd_addr;
  logic [DATA_W-1:0] w_rd_data;
  acc_req_t          acc_req;
  logic [ACC_W-1:0]  acc_rd_data;

  sfma_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .w_wr_en     (w_wr_en),
    .w_wr_addr   (w_wr_addr),
    .w_wr_data   (w_wr_data),
    .w_rd_en     (w_rd_en),
    .w_rd_addr   (w_rd_addr),
    .w_rd_data   (w_rd_data),
    .acc_req     (acc_req),
    .acc_rd_data (acc_rd_data)
  );

  sfma_weight_mem #(
    .DEPTH (WDEPTH)
  ) u_weight_mem (
    .clk     (clk),
    .wr_en   (w_wr_en),
    .wr_addr (w_wr_addr),
    .wr_data (w_wr_data),
    .rd_en   (w_rd_en),
    .rd_addr (w_rd_addr),
    .rd_data (w_rd_data)
  );

  sfma_acc_mem u_acc_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (acc_req),
    .rd_data (acc_rd_data)
  );

endmodule

[verif/sparse_fiber_matrix_accumulate_test.sv]
`timescale 1ns / 1ps
// Testbench for sparse_fiber_matrix_accumulate: drives matrix loads and fiber nonzeros,
// predicts every output row in Q16.16 with 48-bit sums, and checks each result in order.
// Depends on sfma_pkg and the sparse_fiber_matrix_accumulate RTL.
module sparse_fiber_matrix_accumulate_test;
  import sfma_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int PHASE_ITEMS    = 10;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic [31:0]      weight_q [0:255][0:15];
  bit               loaded_q [0:255][0:15];
  logic [47:0]      acc_q [0:15];
  logic [CFG_W-1:0] cols_reg = CFG_COLS_RESET;
  out_item_t        pending_results [$];

  int fail_count = 0;
  int burst_left = 0;
  int hold_off_cycles = 0;
  int stall_cycles = 0;

  sparse_fiber_matrix_accumulate uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic int active_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > 16) return 16;
    return int'(cols_reg);
  endfunction

  function automatic logic [47:0] mul_q16(input logic [31:0] a, input logic [31:0] b);
    longint pa;
    longint pb;
    longint prod;
    pa = longint'($signed(a));
    pb = longint'($signed(b));
    prod = (pa * pb) >>> 16;
    return prod[47:0];
  endfunction

  function automatic logic [31:0] clamp_q16(input logic [47:0] a);
    longint s;
    s = longint'($signed(a));
    if (s > 64'sd2147483647) return 32'h7FFFFFFF;
    if (s < -64'sd2147483648) return 32'h80000000;
    return s[31:0];
  endfunction

  function automatic bit row_loaded(input logic [7:0] row);
    int k;
    for (k = 0; k < active_cols(); k++) begin
      if (!loaded_q[row][k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void accumulate_item(input in_item_t it);
    int n;
    int k;
    out_item_t r;
    n = active_cols();
    if (it.command == CMD_LOAD) begin
      weight_q[it.row_index][it.col_index] = it.data_value;
      loaded_q[it.row_index][it.col_index] = 1'b1;
      return;
    end
    for (k = 0; k < n; k++) begin
      acc_q[k] = acc_q[k] + mul_q16(it.data_value, weight_q[it.row_index][k]);
    end
    if (it.fiber_end) begin
      for (k = 0; k < n; k++) begin
        r.out_col   = 4'(k);
        r.out_value = clamp_q16(acc_q[k]);
        r.out_last  = (k == n - 1);
        pending_results.push_back(r);
      end
      for (k = 0; k < 16; k++) begin
        acc_q[k] = '0;
      end
    end
  endfunction

  function automatic logic [31:0] pick_data();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3, 4: return {{14{v[17]}}, v[17:0]};
      default: return v;
    endcase
  endfunction

  task automatic send_item(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    accumulate_item(item);
    @(negedge clk);
  endtask

  task automatic load_entry(input logic [7:0] row, input logic [3:0] col,
                            input logic [31:0] val);
    in_item_t it;
    it.command    = CMD_LOAD;
    it.row_index  = row;
    it.col_index  = col;
    it.data_value = val;
    it.fiber_end  = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  task automatic send_nonzero(input logic [7:0] row, input logic [31:0] val, input logic fend);
    in_item_t it;
    it.command    = CMD_NONZERO;
    it.row_index  = row;
    it.col_index  = 4'($urandom_range(0, 15));
    it.data_value = val;
    it.fiber_end  = fend;
    send_item(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_columns(input logic [CFG_W-1:0] width);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= width;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cols_reg  = width;
  endtask

  task automatic test_saturation_and_rounding();
    set_columns(5'd2);
    load_entry(8'd0, 4'd0, 32'h80000000);
    load_entry(8'd0, 4'd1, 32'h7FFFFFFF);
    load_entry(8'd255, 4'd0, 32'h00010000);
    load_entry(8'd255, 4'd1, 32'h00000001);
    // wrap the 48-bit sum past its sign bit
    send_nonzero(8'd0, 32'h80000000, 1'b0);
    send_nonzero(8'd0, 32'h80000000, 1'b1);
    send_nonzero(8'd255, 32'hFFFFFFFF, 1'b1);
    send_nonzero(8'd0, 32'h7FFFFFFF, 1'b1);
    send_nonzero(8'd255, 32'h00018000, 1'b1);
    send_nonzero(8'd0, 32'h00000000, 1'b1);
  endtask

  task automatic test_column_count();
    int k;
    for (k = 2; k < 16; k++) begin
      load_entry(8'd255, 4'(k), pick_data());
    end
    set_columns(5'd0);
    send_nonzero(8'd255, pick_data(), 1'b1);
    set_columns(5'd17);
    send_nonzero(8'd255, pick_data(), 1'b0);
    send_nonzero(8'd255, pick_data(), 1'b1);
    set_columns(5'd31);
    send_nonzero(8'd255, pick_data(), 1'b1);
  endtask

  task automatic test_width_change_in_fiber();
    set_columns(5'd16);
    send_nonzero(8'd255, pick_data(), 1'b0);
    set_columns(5'd3);
    send_nonzero(8'd255, pick_data(), 1'b1);
    set_columns(5'd16);
    send_nonzero(8'd255, 32'h00010000, 1'b1);
  endtask

  task automatic test_backpressure();
    int k;
    set_columns(5'd4);
    hold_off_cycles = 300;
    for (k = 0; k < 40; k++) begin
      send_nonzero(8'd255, pick_data(), k[0]);
    end
  endtask

  task automatic test_random_traffic();
    logic [7:0]       pool_rows [0:7];
    logic [CFG_W-1:0] widths [0:4];
    logic [7:0]       row;
    int p;
    int k;
    int j;
    int len;
    int sent;
    pool_rows[0] = 8'd0;
    pool_rows[1] = 8'd255;
    for (k = 2; k < 8; k++) begin
      pool_rows[k] = 8'($urandom_range(1, 254));
    end
    widths[0] = 5'd1;
    widths[1] = 5'd16;
    widths[2] = 5'($urandom_range(2, 15));
    widths[3] = 5'd16;
    widths[4] = 5'($urandom_range(2, 15));
    for (k = 0; k < 8; k++) begin
      for (j = 0; j < 16; j++) begin
        load_entry(pool_rows[k], 4'(j), pick_data());
      end
    end
    for (p = 0; p < 5; p++) begin
      set_columns(widths[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 4) == 0) begin
            load_entry(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), pick_data());
          end else begin
            load_entry(pool_rows[$urandom_range(0, 7)], 4'($urandom_range(0, 15)),
                       pick_data());
          end
          sent++;
        end else begin
          len = $urandom_range(1, 4);
          for (j = 0; j < len; j++) begin
            row = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 6) != 0 || !row_loaded(row)) begin
              row = pool_rows[$urandom_range(0, 7)];
            end
            send_nonzero(row, pick_data(), j == len - 1);
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(negedge clk);
        if (hold_off_cycles > 0) begin
          hold_off_cycles--;
          out_ready <= 1'b0;
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual col %0d value %h last %b",
                 $time, out_data.out_col, out_data.out_value, out_data.out_last);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.out_col !== want.out_col) begin
          $display("%0t: out_col mismatch, expected %0d, actual %0d",
                   $time, want.out_col, out_data.out_col);
          fail_count++;
        end
        if (out_data.out_value !== want.out_value) begin
          $display("%0t: out_value mismatch, expected %h, actual %h",
                   $time, want.out_value, out_data.out_value);
          fail_count++;
        end
        if (out_data.out_last !== want.out_last) begin
          $display("%0t: out_last mismatch, expected %b, actual %b",
                   $time, want.out_last, out_data.out_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int k;
    for (k = 0; k < 16; k++) begin
      acc_q[k] = '0;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_saturation_and_rounding();
    test_column_count();
    test_width_change_in_fiber();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/sfma_pkg.sv
hdl/sfma_weight_mem.sv
hdl/sfma_acc_mem.sv
hdl/sfma_seq.sv
hdl/sparse_fiber_matrix_accumulate.sv
verif/sparse_fiber_matrix_accumulate_test.sv
